/* sv/owm_pkg.sv */
// Shared types and constants of the one-wire monitor access engine.
// Used by the channel interfaces, the front and back parts and the top level.
package owm_pkg;

	localparam int OpW = 3;
	localparam int AddrW = 16;
	localparam int ByteW = 8;
	localparam int CountW = 3;
	localparam int TickW = 16;
	localparam int StatusW = 2;
	localparam int ListDepth = 4;

	localparam logic [OpW-1:0] OP_READ = 3'd0;
	localparam logic [OpW-1:0] OP_WRITE = 3'd1;
	localparam logic [OpW-1:0] OP_RAW = 3'd2;
	localparam logic [OpW-1:0] OP_RX = 3'd3;
	localparam logic [OpW-1:0] OP_TICK = 3'd4;

	localparam logic [ByteW-1:0] CMD_READ = 8'h4a;
	localparam logic [ByteW-1:0] CMD_WRITE = 8'h49;

	localparam logic [CountW-1:0] LEN_READ = 3'd3;
	localparam logic [CountW-1:0] LEN_WRITE = 3'd4;
	localparam logic [CountW-1:0] LEN_RAW = 3'd1;

	localparam logic [StatusW-1:0] ST_OK = 2'd0;
	localparam logic [StatusW-1:0] ST_ECHO = 2'd1;
	localparam logic [StatusW-1:0] ST_ACK = 2'd2;
	localparam logic [StatusW-1:0] ST_TIMEOUT = 2'd3;

	localparam logic [TickW-1:0] TIMEOUT_RESET = 16'd500;
	localparam logic [TickW-1:0] TICK_MAX = 16'hffff;

	localparam int QDepth = 4;
	localparam int QPtrW = 2;
	localparam int QCntW = 3;

	localparam int PaddrW = 3;
	localparam int PdataW = 32;
	localparam logic [0:0] REG_TIMEOUT = 1'b0;

	typedef enum logic [1:0] {
		KIND_REQ,
		KIND_RX,
		KIND_TICK
	} owm_kind_t;

	typedef struct packed {
		owm_kind_t kind;
		logic [CountW-1:0] count;
		logic is_read;
		logic [ListDepth-1:0][ByteW-1:0] bytes;
	} owm_cmd_t;

endpackage

/* sv/owm_if.sv */
// Handshake channels of the access engine: the item channel and the result channel.
// Depends on owm_pkg for field widths.
interface owm_cmd_if;
	logic valid;
	logic ready;
	logic [owm_pkg::OpW-1:0] op;
	logic [owm_pkg::AddrW-1:0] address;
	logic [owm_pkg::ByteW-1:0] wr_data;
	logic [owm_pkg::ByteW-1:0] rx_byte;

	modport source (output valid, op, address, wr_data, rx_byte, input ready);
	modport sink (input valid, op, address, wr_data, rx_byte, output ready);
endinterface

interface owm_res_if;
	logic valid;
	logic ready;
	logic send_valid;
	logic [owm_pkg::ByteW-1:0] send_byte;
	logic done_res;
	logic [owm_pkg::StatusW-1:0] status;
	logic [owm_pkg::ByteW-1:0] read_data;

	modport source (output valid, send_valid, send_byte, done_res, status, read_data,
		input ready);
	modport sink (input valid, send_valid, send_byte, done_res, status, read_data,
		output ready);
endinterface

/* sv/owm_front.sv */
// Front part: accepts item beats, classifies them and queues the commands.
// Depends on owm_pkg and owm_cmd_if.
module owm_front (
	input  logic                clk,
	input  logic                arst_n,
	owm_cmd_if.sink             cmd,
	output logic                q_valid,
	output owm_pkg::owm_cmd_t   q_entry,
	input  logic                q_pop
);

	owm_pkg::owm_cmd_t mem_q [owm_pkg::QDepth];
	logic [owm_pkg::QPtrW-1:0] wr_ptr_q;
	logic [owm_pkg::QPtrW-1:0] rd_ptr_q;
	logic [owm_pkg::QCntW-1:0] cnt_q;
	owm_pkg::owm_cmd_t dec;
	logic keep;
	logic push;
	logic pop;

	always_comb begin
		dec = '0;
		keep = 1'b1;
		unique case (cmd.op)
			owm_pkg::OP_READ: begin
				dec.kind = owm_pkg::KIND_REQ;
				dec.count = owm_pkg::LEN_READ;
				dec.is_read = 1'b1;
				dec.bytes[0] = owm_pkg::CMD_READ;
				dec.bytes[1] = cmd.address[15:8];
				dec.bytes[2] = cmd.address[7:0];
			end
			owm_pkg::OP_WRITE: begin
				dec.kind = owm_pkg::KIND_REQ;
				dec.count = owm_pkg::LEN_WRITE;
				dec.bytes[0] = owm_pkg::CMD_WRITE;
				dec.bytes[1] = cmd.address[15:8];
				dec.bytes[2] = cmd.address[7:0];
				dec.bytes[3] = cmd.wr_data;
			end
			owm_pkg::OP_RAW: begin
				dec.kind = owm_pkg::KIND_REQ;
				dec.count = owm_pkg::LEN_RAW;
				dec.bytes[0] = cmd.wr_data;
			end
			owm_pkg::OP_RX: begin
				dec.kind = owm_pkg::KIND_RX;
				dec.bytes[0] = cmd.rx_byte;
			end
			owm_pkg::OP_TICK: begin
				dec.kind = owm_pkg::KIND_TICK;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign cmd.ready = (cnt_q != owm_pkg::QCntW'(owm_pkg::QDepth));
	assign push = cmd.valid && cmd.ready && keep;
	assign q_valid = (cnt_q != '0);
	assign pop = q_pop && q_valid;
	assign q_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* sv/owm_back.sv */
// Back part: runs the access sequence for queued commands and registers the results.
// Depends on owm_pkg and owm_res_if.
module owm_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [owm_pkg::TickW-1:0]   timeout,
	input  logic                        q_valid,
	input  owm_pkg::owm_cmd_t           q_entry,
	output logic                        q_pop,
	owm_res_if.source                   res
);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ECHO,
		PH_ACK,
		PH_DATA
	} phase_t;

	phase_t phase_q, phase_d;
	logic [owm_pkg::ListDepth-1:0][owm_pkg::ByteW-1:0] list_q;
	logic [owm_pkg::CountW-1:0] count_q, count_d;
	logic [owm_pkg::CountW-1:0] idx_q, idx_d, idx_inc;
	logic is_read_q, is_read_d;
	logic [owm_pkg::TickW-1:0] tick_q, tick_d, tick_inc;
	logic [owm_pkg::ByteW-1:0] cur_byte, next_byte;
	logic proceed, fire, load;
	logic send, finish;
	logic [owm_pkg::ByteW-1:0] send_byte_d;
	logic [owm_pkg::StatusW-1:0] fin_status;
	logic [owm_pkg::ByteW-1:0] fin_data;

	logic res_valid_q;
	logic res_send_q;
	logic [owm_pkg::ByteW-1:0] res_byte_q;
	logic res_done_q;
	logic [owm_pkg::StatusW-1:0] res_status_q;
	logic [owm_pkg::ByteW-1:0] res_data_q;

	assign proceed = !res_valid_q || res.ready;
	assign q_pop = proceed;
	assign fire = q_valid && proceed;
	assign idx_inc = idx_q + 1'b1;
	assign tick_inc = (tick_q == owm_pkg::TICK_MAX) ? tick_q : tick_q + 1'b1;
	assign cur_byte = list_q[idx_q[1:0]];
	assign next_byte = list_q[idx_inc[1:0]];

	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		idx_d = idx_q;
		is_read_d = is_read_q;
		tick_d = tick_q;
		load = 1'b0;
		send = 1'b0;
		send_byte_d = '0;
		finish = 1'b0;
		fin_status = owm_pkg::ST_OK;
		fin_data = '0;
		if (fire) begin
			unique case (q_entry.kind)
				owm_pkg::KIND_REQ: begin
					if (phase_q == PH_IDLE) begin
						load = 1'b1;
						count_d = q_entry.count;
						idx_d = '0;
						is_read_d = q_entry.is_read;
						tick_d = '0;
						phase_d = PH_ECHO;
						send = 1'b1;
						send_byte_d = q_entry.bytes[0];
					end
				end
				owm_pkg::KIND_RX: begin
					unique case (phase_q)
						PH_ECHO: begin
							if (q_entry.bytes[0] != cur_byte) begin
								finish = 1'b1;
								fin_status = owm_pkg::ST_ECHO;
							end else begin
								phase_d = PH_ACK;
								tick_d = '0;
							end
						end
						PH_ACK: begin
							if (q_entry.bytes[0] != cur_byte) begin
								finish = 1'b1;
								fin_status = owm_pkg::ST_ACK;
							end else begin
								idx_d = idx_inc;
								tick_d = '0;
								if (idx_inc < count_q) begin
									phase_d = PH_ECHO;
									send = 1'b1;
									send_byte_d = next_byte;
								end else if (is_read_q) begin
									phase_d = PH_DATA;
								end else begin
									finish = 1'b1;
								end
							end
						end
						PH_DATA: begin
							finish = 1'b1;
							fin_data = q_entry.bytes[0];
						end
						default: begin
						end
					endcase
				end
				owm_pkg::KIND_TICK: begin
					if (phase_q != PH_IDLE) begin
						tick_d = tick_inc;
						if (tick_inc >= timeout) begin
							finish = 1'b1;
							fin_status = owm_pkg::ST_TIMEOUT;
						end
					end
				end
				default: begin
				end
			endcase
		end
		if (finish) begin
			phase_d = PH_IDLE;
			tick_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			list_q <= q_entry.bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			idx_q <= '0;
			is_read_q <= 1'b0;
			tick_q <= '0;
			res_valid_q <= 1'b0;
			res_send_q <= 1'b0;
			res_byte_q <= '0;
			res_done_q <= 1'b0;
			res_status_q <= owm_pkg::ST_OK;
			res_data_q <= '0;
		end else begin
			phase_q <= phase_d;
			count_q <= count_d;
			idx_q <= idx_d;
			is_read_q <= is_read_d;
			tick_q <= tick_d;
			if (send || finish) begin
				res_valid_q <= 1'b1;
				res_send_q <= send;
				res_byte_q <= send_byte_d;
				res_done_q <= finish;
				res_status_q <= fin_status;
				res_data_q <= fin_data;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid = res_valid_q;
	assign res.send_valid = res_send_q;
	assign res.send_byte = res_byte_q;
	assign res.done_res = res_done_q;
	assign res.status = res_status_q;
	assign res.read_data = res_data_q;

endmodule

/* sv/one_wire_monitor_access_engine.sv */
// Top level of the one-wire monitor access engine: register port, front and back parts.
// Depends on owm_pkg, owm_if, owm_front and owm_back.
//
//   channel  dir  beat carries
//   cmd      in   op, address, wr_data, rx_byte
//   res      out  send_valid, send_byte, done_res, status, read_data
//   apb      in   timeout_ticks at byte address 0
//
// The back part takes one beat per cycle while no result is stalled.
// Results are registered in the back part from beats taken at the head of a four-entry queue.
// Reset leaves the engine idle with timeout_ticks at 500 and the queue empty.
// A stalled result holds the back part; the queue keeps taking beats until full.
module one_wire_monitor_access_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	owm_cmd_if.sink                       cmd,
	owm_res_if.source                     res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [owm_pkg::PaddrW-1:0]    paddr,
	input  logic [owm_pkg::PdataW-1:0]    pwdata,
	output logic [owm_pkg::PdataW-1:0]    prdata,
	output logic                          pready
);

	logic [owm_pkg::TickW-1:0] timeout_q;
	logic q_valid;
	logic q_pop;
	owm_pkg::owm_cmd_t q_entry;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= owm_pkg::TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[owm_pkg::PaddrW-1] == owm_pkg::REG_TIMEOUT) begin
			timeout_q <= pwdata[owm_pkg::TickW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[owm_pkg::PaddrW-1] == owm_pkg::REG_TIMEOUT) begin
			prdata = owm_pkg::PdataW'(timeout_q);
		end
	end

	owm_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop)
	);

	owm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.timeout (timeout_q),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop),
		.res     (res)
	);

	// A classified beat always leaves the queue non-empty on the next cycle.
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready && cmd.op <= owm_pkg::OP_TICK |=> q_valid)
		else $error("accepted command did not reach the queue");

	// A new result only comes from a command taken from the queue.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(q_valid && q_pop))
		else $error("result appeared without a queued command");

	// Every result either sends a byte or ends an access, never both.
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.send_valid != res.done_res))
		else $error("result is neither a send nor a completion");

endmodule
